@@ rtl/gha_pkg.sv @@
`timescale 1ns / 1ps
package gha_pkg;

	localparam int NUM_TABLES = 4;
	localparam int SLOTS      = 1024;

	localparam int MODE_W  = 2;
	localparam int TREQ_W  = 2;
	localparam int SLOT_W  = 10;
	localparam int VER_W   = 32;
	localparam int STAT_W  = 2;
	localparam int TBL_W   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int DEPTH   = NUM_TABLES * SLOTS;
	localparam int ADDR_W  = $clog2(DEPTH);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [VER_W-1:0]  ver_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [TBL_W-1:0]  tidx_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_CREATE  = 2'd0,
		MODE_DESTROY = 2'd1,
		MODE_QUERY   = 2'd2,
		MODE_SPARE   = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_ALIVE = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	function automatic addr_t slot_addr(tidx_t t, slot_t s);
		return addr_t'(ADDR_W'(t) * ADDR_W'(SLOTS) + ADDR_W'(s));
	endfunction

endpackage

@@ rtl/gha_req_if.sv @@
`timescale 1ns / 1ps
interface gha_req_if
	import gha_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [TREQ_W-1:0] table_req;
	logic [SLOT_W-1:0] slot_id;
	logic [VER_W-1:0]  version;

	modport source (output valid, mode, table_req, slot_id, version, input ready);
	modport sink   (input valid, mode, table_req, slot_id, version, output ready);
endinterface

@@ rtl/gha_rsp_if.sv @@
`timescale 1ns / 1ps
interface gha_rsp_if
	import gha_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              alive;
	logic [SLOT_W-1:0] new_slot;
	logic [VER_W-1:0]  new_version;

	modport source (output valid, status, alive, new_slot, new_version, input ready);
	modport sink   (input valid, status, alive, new_slot, new_version, output ready);
endinterface

@@ rtl/gha_ram.sv @@
`timescale 1ns / 1ps
module gha_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/generational_handle_allocator_top.sv @@
`timescale 1ns / 1ps
// Channel | Role | Payload
// req     | sink   | mode, table_req, slot_id, version
// rsp     | source | status, alive, new_slot, new_version
//
// One request at a time: accept, then a synchronous read of the version or
// free-stack memory in S_LOOK; create from the free stack adds S_POP for the
// dependent version read. Reset clears the per-table stack depths and
// high-water counts; memories hold garbage until written. A result waits in the
// output register while the next request is taken; the engine stalls only when
// that register is still full.
module generational_handle_allocator_top
	import gha_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	gha_req_if.sink  req,
	gha_rsp_if.source rsp
);

	typedef enum logic [1:0] {S_IDLE, S_LOOK, S_POP} state_t;

	state_t  state_q, state_d;
	mode_t   mode_q;
	tidx_t   tidx_q;
	logic    tvalid_q;
	slot_t   slot_q, slot_d;
	ver_t    ver_q;
	cnt_t    fc_q   [NUM_TABLES];
	cnt_t    mark_q [NUM_TABLES];
	cnt_t    fc_d, mark_d;
	logic    fc_we, mark_we;

	logic    rsp_valid_q;
	status_t rsp_status_q, rsp_status_d;
	logic    rsp_alive_q, rsp_alive_d;
	slot_t   rsp_slot_q, rsp_slot_d;
	ver_t    rsp_ver_q, rsp_ver_d;
	logic    finish;

	logic    accept, out_free;
	tidx_t   req_tidx;
	logic    req_tvalid;
	cnt_t    req_fc;

	logic    ver_we, ver_re, stk_we, stk_re;
	addr_t   ver_waddr, ver_raddr, stk_waddr, stk_raddr;
	ver_t    ver_wdata, ver_rdata;
	slot_t   stk_wdata, stk_rdata;

	cnt_t    fc_cur, mark_cur;
	logic    live;

	gha_ram #(.WIDTH(VER_W), .DEPTH(DEPTH)) u_ver_ram (
		.clk(clk), .we(ver_we), .waddr(ver_waddr), .wdata(ver_wdata),
		.re(ver_re), .raddr(ver_raddr), .rdata(ver_rdata)
	);

	gha_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
	);

	assign out_free   = !rsp_valid_q || rsp.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign req_tidx   = tidx_t'(req.table_req);
	assign req_tvalid = 32'(req.table_req) < 32'(NUM_TABLES);
	assign req_fc     = fc_q[req_tidx];

	assign fc_cur   = fc_q[tidx_q];
	assign mark_cur = mark_q[tidx_q];
	assign live     = tvalid_q && ver_q[0] && (CNT_W'(slot_q) < mark_cur) &&
	                  (ver_rdata == ver_q);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.alive       = rsp_alive_q;
	assign rsp.new_slot    = rsp_slot_q;
	assign rsp.new_version = rsp_ver_q;

	always_comb begin
		state_d      = state_q;
		slot_d       = slot_q;
		fc_d         = fc_cur;
		mark_d       = mark_cur;
		fc_we        = 1'b0;
		mark_we      = 1'b0;
		finish       = 1'b0;
		rsp_status_d = ST_DONE;
		rsp_alive_d  = 1'b0;
		rsp_slot_d   = '0;
		rsp_ver_d    = '0;
		ver_we       = 1'b0;
		ver_waddr    = slot_addr(tidx_q, slot_q);
		ver_wdata    = '0;
		stk_we       = 1'b0;
		stk_waddr    = slot_addr(tidx_q, slot_t'(fc_cur));
		stk_wdata    = slot_q;
		ver_re       = 1'b0;
		ver_raddr    = slot_addr(req_tidx, req.slot_id);
		stk_re       = 1'b0;
		stk_raddr    = slot_addr(req_tidx, slot_t'(cnt_t'(req_fc - cnt_t'(1))));

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode_t'(req.mode) == MODE_CREATE) begin
						stk_re = 1'b1;
					end else begin
						ver_re = 1'b1;
					end
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				unique case (mode_q)
					MODE_CREATE: begin
						if (!tvalid_q) begin
							if (out_free) begin
								finish       = 1'b1;
								rsp_status_d = ST_FULL;
							end
						end else if (fc_cur != '0) begin
							// pop: fetch the version of the reused slot
							slot_d    = (32'(stk_rdata) < 32'(SLOTS)) ? stk_rdata : '0;
							ver_re    = 1'b1;
							ver_raddr = slot_addr(tidx_q, slot_d);
							state_d   = S_POP;
						end else if (mark_cur < cnt_t'(SLOTS)) begin
							if (out_free) begin
								finish     = 1'b1;
								ver_we     = 1'b1;
								ver_waddr  = slot_addr(tidx_q, slot_t'(mark_cur));
								ver_wdata  = ver_t'(1);
								mark_d     = cnt_t'(mark_cur + cnt_t'(1));
								mark_we    = 1'b1;
								rsp_slot_d = slot_t'(mark_cur);
								rsp_ver_d  = ver_t'(1);
							end
						end else if (out_free) begin
							finish       = 1'b1;
							rsp_status_d = ST_FULL;
						end
					end
					MODE_DESTROY: begin
						if (out_free) begin
							finish = 1'b1;
							if (live) begin
								rsp_alive_d = 1'b1;
								ver_we      = 1'b1;
								// next even value of an odd word
								ver_wdata   = ver_t'(ver_rdata + ver_t'(1));
								if (fc_cur < cnt_t'(SLOTS)) begin
									stk_we = 1'b1;
									fc_d   = cnt_t'(fc_cur + cnt_t'(1));
									fc_we  = 1'b1;
								end
							end else begin
								rsp_status_d = ST_NOT_ALIVE;
							end
						end
					end
					MODE_QUERY, MODE_SPARE: begin
						if (out_free) begin
							finish      = 1'b1;
							rsp_alive_d = live;
						end
					end
					default: ;
				endcase
				if (finish) begin
					state_d = S_IDLE;
				end
			end
			S_POP: begin
				if (out_free) begin
					finish     = 1'b1;
					ver_we     = 1'b1;
					ver_wdata  = ver_rdata | ver_t'(1);
					fc_d       = cnt_t'(fc_cur - cnt_t'(1));
					fc_we      = 1'b1;
					rsp_slot_d = slot_q;
					rsp_ver_d  = ver_wdata;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_DONE;
			rsp_alive_q  <= 1'b0;
			rsp_slot_q   <= '0;
			rsp_ver_q    <= '0;
			for (int i = 0; i < NUM_TABLES; i++) begin
				fc_q[i]   <= '0;
				mark_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (finish) begin
				rsp_valid_q  <= 1'b1;
				rsp_status_q <= rsp_status_d;
				rsp_alive_q  <= rsp_alive_d;
				rsp_slot_q   <= rsp_slot_d;
				rsp_ver_q    <= rsp_ver_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (fc_we) begin
				fc_q[tidx_q] <= fc_d;
			end
			if (mark_we) begin
				mark_q[tidx_q] <= mark_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode_t'(req.mode);
			tidx_q   <= req_tidx;
			tvalid_q <= req_tvalid;
			slot_q   <= req.slot_id;
			ver_q    <= req.version;
		end else begin
			slot_q <= slot_d;
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_LOOK)
		else $error("request accepted but engine did not start");

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> out_free)
		else $error("result overwrote a pending output");

	a_grant_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && rsp_status_d == ST_DONE && mode_q == MODE_CREATE) |-> rsp_ver_d[0])
		else $error("create granted an even version");

	a_one_counter_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(fc_we && mark_we))
		else $error("stack depth and high-water count written together");

	for (genvar g = 0; g < NUM_TABLES; g++) begin : g_chk
		a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
			(fc_q[g] <= mark_q[g]) && (mark_q[g] <= cnt_t'(SLOTS)))
			else $error("free stack deeper than claimed slots");
	end

endmodule

@@ test/generational_handle_allocator_top_tb.sv @@
`timescale 1ns / 1ps
module generational_handle_allocator_top_tb;
	import gha_pkg::*;

	localparam int IDLE_LIMIT  = 5000;
	localparam int RAND_ITEMS  = 860;
	localparam int CALM_ITEMS  = 150;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_WAIT  = 8;
	localparam int FILL_TABLE  = 1;

	typedef struct packed {
		status_t status;
		logic    alive;
		slot_t   new_slot;
		ver_t    new_version;
	} handle_rsp_t;

	typedef struct packed {
		mode_t       mode;
		logic [1:0]  tbl;
		slot_t       slot;
		ver_t        ver;
		logic        typed;
		handle_rsp_t rsp;
	} op_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gha_req_if req();
	gha_rsp_if rsp();

	generational_handle_allocator_top DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the allocator tables
	bit [VER_W-1:0]  ver_mem   [NUM_TABLES][SLOTS];
	bit [SLOT_W-1:0] free_slot [NUM_TABLES][SLOTS];
	int unsigned     free_depth[NUM_TABLES];
	int unsigned     hw_mark   [NUM_TABLES];
	slot_t           live_slots[NUM_TABLES][$];

	handle_rsp_t pending_rsp[$];
	int unsigned mismatch_count = 0;
	int unsigned n_sent = 0;
	int unsigned idle_cycles = 0;
	bit          calm = 1'b0;
	bit          held = 1'b0;

	op_row_t directed_ops [0:23] = '{
		'{MODE_QUERY,   2'd0, 10'd0,    32'd1,          1'b1, '{ST_DONE,      1'b0, 10'd0, 32'd0}},
		'{MODE_DESTROY, 2'd0, 10'd0,    32'd1,          1'b1, '{ST_NOT_ALIVE, 1'b0, 10'd0, 32'd0}},
		'{MODE_CREATE,  2'd0, 10'd0,    32'd0,          1'b1, '{ST_DONE,      1'b0, 10'd0, 32'd1}},
		'{MODE_CREATE,  2'd0, 10'd1023, 32'hFFFF_FFFF,  1'b1, '{ST_DONE,      1'b0, 10'd1, 32'd1}},
		'{MODE_QUERY,   2'd0, 10'd0,    32'd1,          1'b1, '{ST_DONE,      1'b1, 10'd0, 32'd0}},
		'{MODE_SPARE,   2'd0, 10'd1,    32'd1,          1'b1, '{ST_DONE,      1'b1, 10'd0, 32'd0}},
		'{MODE_QUERY,   2'd0, 10'd0,    32'd0,          1'b1, '{ST_DONE,      1'b0, 10'd0, 32'd0}},
		'{MODE_QUERY,   2'd0, 10'd1023, 32'hFFFF_FFFF,  1'b1, '{ST_DONE,      1'b0, 10'd0, 32'd0}},
		'{MODE_DESTROY, 2'd0, 10'd0,    32'd1,          1'b1, '{ST_DONE,      1'b1, 10'd0, 32'd0}},
		'{MODE_DESTROY, 2'd0, 10'd0,    32'd1,          1'b1, '{ST_NOT_ALIVE, 1'b0, 10'd0, 32'd0}},
		'{MODE_QUERY,   2'd0, 10'd0,    32'd1,          1'b1, '{ST_DONE,      1'b0, 10'd0, 32'd0}},
		'{MODE_CREATE,  2'd0, 10'd0,    32'd0,          1'b1, '{ST_DONE,      1'b0, 10'd0, 32'd3}},
		'{MODE_DESTROY, 2'd0, 10'd1,    32'd1,          1'b1, '{ST_DONE,      1'b1, 10'd0, 32'd0}},
		'{MODE_DESTROY, 2'd0, 10'd0,    32'd3,          1'b1, '{ST_DONE,      1'b1, 10'd0, 32'd0}},
		'{MODE_DESTROY, 2'd0, 10'd0,    32'd2,          1'b1, '{ST_NOT_ALIVE, 1'b0, 10'd0, 32'd0}},
		'{MODE_CREATE,  2'd0, 10'd0,    32'd0,          1'b0, '{ST_DONE,      1'b0, 10'd0, 32'd0}},
		'{MODE_CREATE,  2'd0, 10'd0,    32'd0,          1'b0, '{ST_DONE,      1'b0, 10'd0, 32'd0}},
		'{MODE_CREATE,  2'd0, 10'd0,    32'd0,          1'b0, '{ST_DONE,      1'b0, 10'd0, 32'd0}},
		'{MODE_CREATE,  2'd3, 10'd1023, 32'hFFFF_FFFF,  1'b1, '{ST_DONE,      1'b0, 10'd0, 32'd1}},
		'{MODE_QUERY,   2'd3, 10'd0,    32'hFFFF_FFFF,  1'b1, '{ST_DONE,      1'b0, 10'd0, 32'd0}},
		'{MODE_DESTROY, 2'd3, 10'd1023, 32'hFFFF_FFFF,  1'b1, '{ST_NOT_ALIVE, 1'b0, 10'd0, 32'd0}},
		'{MODE_DESTROY, 2'd2, 10'd0,    32'd1,          1'b1, '{ST_NOT_ALIVE, 1'b0, 10'd0, 32'd0}},
		'{MODE_SPARE,   2'd0, 10'd2,    32'd1,          1'b0, '{ST_DONE,      1'b0, 10'd0, 32'd0}},
		'{MODE_QUERY,   2'd0, 10'd0,    32'd5,          1'b0, '{ST_DONE,      1'b0, 10'd0, 32'd0}}
	};

	function automatic bit handle_is_live(int unsigned t, slot_t s, ver_t v);
		if (t >= NUM_TABLES || !v[0])
			return 1'b0;
		if (int'(s) >= int'(hw_mark[t]) || int'(s) >= SLOTS)
			return 1'b0;
		return ver_mem[t][s] == v;
	endfunction

	// apply one operation to the shadow tables and return the response it should produce
	function automatic handle_rsp_t apply_handle_op(mode_t m, int unsigned t, slot_t s, ver_t v);
		handle_rsp_t r;
		slot_t       got;
		r = '{ST_DONE, 1'b0, '0, '0};
		case (m)
			MODE_CREATE: begin
				if (t >= NUM_TABLES) begin
					r.status = ST_FULL;
				end else if (free_depth[t] > 0 && free_depth[t] <= SLOTS) begin
					free_depth[t]--;
					got = free_slot[t][free_depth[t]];
					ver_mem[t][got] |= 32'd1;
					r.new_slot = got;
					r.new_version = ver_mem[t][got];
				end else if (hw_mark[t] < SLOTS) begin
					got = slot_t'(hw_mark[t]);
					ver_mem[t][got] = 32'd1;
					hw_mark[t]++;
					r.new_slot = got;
					r.new_version = ver_mem[t][got];
				end else begin
					r.status = ST_FULL;
				end
			end
			MODE_DESTROY: begin
				if (handle_is_live(t, s, v)) begin
					r.alive = 1'b1;
					ver_mem[t][s] = (ver_mem[t][s] + 32'd2) & ~32'd1;
					if (free_depth[t] < SLOTS) begin
						free_slot[t][free_depth[t]] = s;
						free_depth[t]++;
					end
				end else begin
					r.status = ST_NOT_ALIVE;
				end
			end
			default: r.alive = handle_is_live(t, s, v);
		endcase
		return r;
	endfunction

	// offer one request, wait for the transaction, then record what should come back
	task automatic offer_op(mode_t m, logic [1:0] t, slot_t s, ver_t v, bit typed,
			handle_rsp_t typed_rsp);
		handle_rsp_t r;
		int          idx;
		@(negedge clk);
		if (!calm && $urandom_range(0, 7) == 0) begin
			req.valid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		req.valid     = 1'b1;
		req.mode      = m;
		req.table_req = t;
		req.slot_id   = s;
		req.version   = v;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		n_sent++;
		r = apply_handle_op(m, t, s, v);
		pending_rsp.push_back(typed ? typed_rsp : r);
		if (m == MODE_CREATE && r.status == ST_DONE)
			live_slots[t].push_back(r.new_slot);
		if (m == MODE_DESTROY && r.alive) begin
			for (idx = 0; idx < live_slots[t].size(); idx++)
				if (live_slots[t][idx] == s) begin
					live_slots[t].delete(idx);
					break;
				end
		end
	endtask

	// a handle that looks plausible but is not live
	task automatic pick_stale(int unsigned t, output slot_t s, output ver_t v);
		int unsigned hw;
		hw = hw_mark[t];
		s = slot_t'($urandom());
		v = $urandom();
		case ($urandom_range(0, 3))
			0: if (hw > 0) begin
				s = slot_t'($urandom_range(0, hw - 1));
				v = ver_mem[t][s][0] ? ver_mem[t][s] - 32'd2 : ver_mem[t][s] - 32'd1;
			end
			1: begin
				s = slot_t'($urandom_range((hw < SLOTS) ? hw : 0, SLOTS - 1));
				v = $urandom() | 32'd1;
			end
			2: ;
			default: if (live_slots[t].size() > 0) begin
				s = live_slots[t][$urandom_range(0, live_slots[t].size() - 1)];
				v = ver_mem[t][s] ^ 32'd1;
			end
		endcase
	endtask

	task automatic random_op();
		int unsigned t;
		int unsigned pick;
		slot_t       s;
		ver_t        v;
		mode_t       m;
		t = $urandom_range(0, NUM_TABLES - 1);
		pick = $urandom_range(0, 99);
		s = slot_t'($urandom());
		v = $urandom();
		m = MODE_CREATE;
		if (pick >= 35 && pick < 84 && live_slots[t].size() > 0 && !(pick >= 60 && pick < 68)) begin
			s = live_slots[t][$urandom_range(0, live_slots[t].size() - 1)];
			v = ver_mem[t][s];
			m = (pick < 60) ? MODE_DESTROY : ($urandom_range(0, 1) ? MODE_QUERY : MODE_SPARE);
		end else if (pick >= 60 && pick < 68) begin
			pick_stale(t, s, v);
			m = MODE_DESTROY;
		end else if (pick >= 84) begin
			pick_stale(t, s, v);
			m = $urandom_range(0, 1) ? MODE_QUERY : MODE_SPARE;
		end
		offer_op(m, 2'(t), s, v, 1'b0, '0);
	endtask

	// sender
	initial begin
		int i;
		req.valid     = 1'b0;
		req.mode      = MODE_CREATE;
		req.table_req = '0;
		req.slot_id   = '0;
		req.version   = '0;
		for (i = 0; i < NUM_TABLES; i++) begin
			free_depth[i] = 0;
			hw_mark[i] = 0;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_ops[k])
			offer_op(directed_ops[k].mode, directed_ops[k].tbl, directed_ops[k].slot,
				directed_ops[k].ver, directed_ops[k].typed, directed_ops[k].rsp);

		// claim every slot of one table, then hit it while full
		while (!(hw_mark[FILL_TABLE] == SLOTS && free_depth[FILL_TABLE] == 0))
			offer_op(MODE_CREATE, 2'(FILL_TABLE), slot_t'($urandom()), $urandom(), 1'b0, '0);
		offer_op(MODE_CREATE, 2'(FILL_TABLE), '0, '0, 1'b1, '{ST_FULL, 1'b0, 10'd0, 32'd0});
		offer_op(MODE_CREATE, 2'(FILL_TABLE), '1, '1, 1'b1, '{ST_FULL, 1'b0, 10'd0, 32'd0});

		for (i = 0; i < RAND_ITEMS; i++) begin
			if (i >= RAND_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			random_op();
		end
		@(negedge clk);
		req.valid = 1'b0;

		wait (pending_rsp.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// receiver
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && n_sent >= HOLD_AT) begin
				// hold off long enough for the block to back up into its input
				held = 1'b1;
				rsp.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				rsp.ready = 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
			end
			rsp.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		handle_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected response status=%0d alive=%0d slot=%0d ver=%h",
						$realtime, rsp.status, rsp.alive, rsp.new_slot, rsp.new_version);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.alive !== want.alive ||
						rsp.new_slot !== want.new_slot || rsp.new_version !== want.new_version) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: expected status=%0d alive=%0d slot=%0d ver=%h, got status=%0d alive=%0d slot=%0d ver=%h",
							$realtime, want.status, want.alive, want.new_slot, want.new_version,
							rsp.status, rsp.alive, rsp.new_slot, rsp.new_version);
				end
			end
		end
	end

	// watchdog: cycles without any transaction on either side
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

@@ files.f @@
rtl/gha_pkg.sv
rtl/gha_req_if.sv
rtl/gha_rsp_if.sv
rtl/gha_ram.sv
rtl/generational_handle_allocator_top.sv
test/generational_handle_allocator_top_tb.sv
